/* src/civ_pkg.sv */
// Shared types and constants for the cubic-interpolation stream average unit.
// Used by civ_scale, cubic_interp_stream_average_unit, civ_mean_checker and tb; depends on nothing.
package civ_pkg;

   localparam int SAMPLE_W = 32;   // Q16.16 sample and mean width
   localparam int SCALE_W  = 32;   // Q0.32 scale register
   localparam int ACC_W    = 56;   // area accumulator
   localparam int DELTA_W  = 40;   // per-sample area increment, |delta| < 96 * 2^31
   localparam int CNT_W    = 3;    // samples seen, holds at CNT_FULL
   localparam int HI_W     = ACC_W - SCALE_W;            // upper accumulator slice
   localparam int PHI_W    = HI_W + SCALE_W + 1;         // signed hi * unsigned scale
   localparam int MSUM_W   = PHI_W + 1;                  // scaled sum before clipping

   localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;
   localparam logic [CNT_W-1:0] CNT_FULL  = 3'd4;

   // Lagrange quadrature weights
   localparam logic signed [DELTA_W-1:0] W_5  = DELTA_W'(5);
   localparam logic signed [DELTA_W-1:0] W_9  = DELTA_W'(9);
   localparam logic signed [DELTA_W-1:0] W_13 = DELTA_W'(13);
   localparam logic signed [DELTA_W-1:0] W_19 = DELTA_W'(19);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic [SAMPLE_W-1:0] MEAN_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] MEAN_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Finished sequence handed from the accumulator to the scaling stages
   typedef struct packed {
      logic [ACC_W-1:0] area;
      logic             too_short;
   } fin_type;

endpackage

/* src/civ_scale.sv */
// Scaling back end: splits area * scale_factor at bit 32 of area into two products,
// sums and clips to 32 bits, and holds the result for the rsp channel. Uses civ_pkg.
module civ_scale
   import civ_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [SCALE_W-1:0]  scale,
   input  logic                fin_valid,
   input  fin_type             fin,
   output logic                fin_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,   // [31:0] mean_value
   output logic [1:0]          rsp_tuser    // [0] too_short, [1] saturated
);

   logic signed [HI_W-1:0]    hi_s;
   logic signed [SCALE_W:0]   sc_s;
   logic signed [PHI_W-1:0]   p_hi_in;
   logic [2*SCALE_W-1:0]      p_lo_in;

   logic                      d_valid_ff;
   logic [PHI_W-1:0]          d_hi_ff;
   logic [SCALE_W-1:0]        d_lo_ff;
   logic                      d_short_ff;

   logic [MSUM_W-1:0]         msum;
   logic                      fits;
   logic [SAMPLE_W-1:0]       mean_in;
   logic                      sat_in;

   logic                      rsp_valid_ff;
   logic [SAMPLE_W-1:0]       rsp_mean_ff;
   logic                      rsp_short_ff;
   logic                      rsp_sat_ff;

   logic                      out_free;
   logic                      d_free;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign d_free    = !d_valid_ff || out_free;
   assign fin_ready = d_free;

   // floor(acc * s / 2^32) = hi * s + ((lo * s) >> 32)
   assign hi_s    = fin.area[ACC_W-1:SCALE_W];
   assign sc_s    = {1'b0, scale};
   assign p_hi_in = hi_s * sc_s;
   assign p_lo_in = {{SCALE_W{1'b0}}, fin.area[SCALE_W-1:0]} * {{SCALE_W{1'b0}}, scale};

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_free) begin
         d_valid_ff <= fin_valid;
      end
      if (d_free && fin_valid) begin
         d_hi_ff    <= p_hi_in;
         d_lo_ff    <= p_lo_in[2*SCALE_W-1:SCALE_W];
         d_short_ff <= fin.too_short;
      end
   end

   assign msum = {d_hi_ff[PHI_W-1], d_hi_ff} + {{(MSUM_W-SCALE_W){1'b0}}, d_lo_ff};
   assign fits = (msum[MSUM_W-1:SAMPLE_W-1] == {(MSUM_W-SAMPLE_W+1){msum[MSUM_W-1]}});

   always_comb begin
      if (d_short_ff) begin
         mean_in = '0;
         sat_in  = 1'b0;
      end else if (fits) begin
         mean_in = msum[SAMPLE_W-1:0];
         sat_in  = 1'b0;
      end else begin
         mean_in = msum[MSUM_W-1] ? MEAN_MIN : MEAN_MAX;
         sat_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= d_valid_ff;
      end
      if (out_free && d_valid_ff) begin
         rsp_mean_ff  <= mean_in;
         rsp_short_ff <= d_short_ff;
         rsp_sat_ff   <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mean_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_short_ff};

   a_short_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_short_ff) |-> (rsp_mean_ff == '0 && !rsp_sat_ff))
      else $error("too_short result carries a nonzero mean or saturation");

   a_sat_is_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |-> (rsp_mean_ff == MEAN_MAX || rsp_mean_ff == MEAN_MIN))
      else $error("saturated result is not at a rail");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_mean_ff)))
      else $error("rsp transfer changed while stalled");

endmodule

/* src/cubic_interp_stream_average_unit.sv */
// Top level of the cubic-interpolation stream average: sample window,
// per-sample quadrature increment and area accumulator. Uses civ_pkg and civ_scale.
//
// Usage:
//   csr channel : one write sets scale_factor (Q0.32, step / (24 * span)).
//                 csr_ready is always high; write only while the block is idle.
//   req channel : one signed Q16.16 sample per transfer, tlast marks the final
//                 sample of a sequence. A transfer can be taken every cycle while rsp is not stalled.
//   rsp channel : one transfer per sequence, on its final sample. tdata is the
//                 mean, tuser[0] flags a sequence of fewer than four samples,
//                 tuser[1] flags clipping to 32 bits.
// Path: a final sample passes stages A and B, fin_ff and both civ_scale stages.
//   Throughput is one sample per cycle unless rsp stalls; the accumulator add with
//   clipping sets the per-cycle path, the 56x32 scaling is split over two stages.
// Reset clears the count, accumulator, pipeline and scale_factor; the window
// is refilled by each sequence before it is used.
// When the rsp side stalls, samples that end no sequence keep flowing; a
// final sample waits in the pipeline until there is room, and req_tready
// drops once the stages fill up.
module cubic_interp_stream_average_unit
   import civ_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SCALE_W-1:0]  csr_wdata,   // [31:0] scale_factor
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // [31:0] sample
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,   // [31:0] mean_value
   output logic [1:0]          rsp_tuser    // [0] too_short, [1] saturated
);

   logic [SCALE_W-1:0]          scale_ff;

   // stage A: registered input
   logic                        a_valid_ff;
   logic [SAMPLE_W-1:0]         a_sample_ff;
   logic                        a_last_ff;
   logic [SAMPLE_W-1:0]         win_ff [3];
   logic [CNT_W-1:0]            seen_ff;
   logic                        a_go;

   // stage B: increment ready to accumulate
   logic                        b_valid_ff;
   logic signed [DELTA_W-1:0]   b_delta_ff;
   logic                        b_en_ff;
   logic                        b_last_ff;
   logic                        b_go;

   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [ACC_W:0]       acc_sum;
   logic signed [ACC_W-1:0]     acc_in;

   logic                        fin_valid_ff;
   fin_type                     fin_ff;
   logic                        fin_ready;
   logic                        fin_free;

   logic signed [DELTA_W-1:0]   f1, f2, f3, f4;
   logic signed [DELTA_W-1:0]   mid_term, first_term, final_term;
   logic signed [DELTA_W-1:0]   delta_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
      end else if (csr_valid) begin
         scale_ff <= csr_wdata;
      end
   end

   // handshake chain
   assign fin_free   = !fin_valid_ff || fin_ready;
   assign b_go       = b_valid_ff && (!b_last_ff || fin_free);
   assign a_go       = a_valid_ff && (!b_valid_ff || b_go);
   assign req_tready = !a_valid_ff || a_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_tready) begin
         a_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         a_sample_ff <= req_tdata;
         a_last_ff   <= req_tlast;
      end
   end

   // window (f1,f2,f3) oldest first, f4 the current sample
   assign f1 = DELTA_W'($signed(win_ff[0]));
   assign f2 = DELTA_W'($signed(win_ff[1]));
   assign f3 = DELTA_W'($signed(win_ff[2]));
   assign f4 = DELTA_W'($signed(a_sample_ff));

   assign mid_term   = W_13 * f2 + W_13 * f3 - f1 - f4;
   assign first_term = W_9 * f1 + W_19 * f2 - W_5 * f3 + f4;
   assign final_term = f1 - W_5 * f2 + W_19 * f3 + W_9 * f4;

   always_comb begin
      delta_in = mid_term;
      if (seen_ff == CNT_THREE) begin
         delta_in = delta_in + first_term;
      end
      if (a_last_ff) begin
         delta_in = delta_in + final_term;
      end
   end

   // window contents are read only after three fresh writes, so no clear needed
   always_ff @(posedge clock) begin
      if (a_go) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= a_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_go) begin
            if (a_last_ff) begin
               seen_ff <= '0;
            end else if (seen_ff != CNT_FULL) begin
               seen_ff <= seen_ff + CNT_W'(1);
            end
         end
         if (a_go) begin
            b_valid_ff <= 1'b1;
         end else if (b_go) begin
            b_valid_ff <= 1'b0;
         end
      end
      if (a_go) begin
         b_delta_ff <= delta_in;
         b_en_ff    <= (seen_ff == CNT_THREE) || (seen_ff == CNT_FULL);
         b_last_ff  <= a_last_ff;
      end
   end

   // clipping accumulate
   assign acc_sum = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(b_delta_ff);

   always_comb begin
      if (!b_en_ff) begin
         acc_in = acc_ff;
      end else if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_in = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = acc_sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         if (b_go) begin
            acc_ff <= b_last_ff ? '0 : acc_in;
         end
         if (b_go && b_last_ff) begin
            fin_valid_ff <= 1'b1;
         end else if (fin_ready) begin
            fin_valid_ff <= 1'b0;
         end
      end
      if (b_go && b_last_ff) begin
         fin_ff.area      <= acc_in;
         fin_ff.too_short <= !b_en_ff;
      end
   end

   civ_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .scale      (scale_ff),
      .fin_valid  (fin_valid_ff),
      .fin        (fin_ff),
      .fin_ready  (fin_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !(seen_ff > CNT_FULL))
      else $error("sample count ran past its hold value");

   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      (a_go && a_last_ff) |=> (seen_ff == '0))
      else $error("sample count not cleared after final sample");

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      (b_go && b_last_ff) |=> (acc_ff == '0 && fin_valid_ff))
      else $error("accumulator not cleared or result lost at sequence end");

   a_short_no_acc: assert property (@(posedge clock) disable iff (reset)
      (b_go && b_last_ff && !b_en_ff) |=> (fin_ff.area == '0))
      else $error("short sequence left a nonzero area");

endmodule

/* verif/civ_mean_checker.sv */
// Checker for the cubic-interpolation stream average: watches the csr, req and rsp
// channels, predicts each sequence mean and compares it with the rsp transfers.
// Depends on civ_pkg for widths and the sample count constants.
module civ_mean_checker
   import civ_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [SCALE_W-1:0]  csr_wdata,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   input  logic                req_tlast,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [SAMPLE_W-1:0] rsp_tdata,
   input  logic [1:0]          rsp_tuser,
   output int                  fail_count,
   output int                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint AREA_TOP = (64'sd1 <<< (ACC_W - 1)) - 1;
   localparam longint AREA_BOT = -AREA_TOP - 1;
   localparam longint MEAN_TOP = 64'sd2147483647;
   localparam longint MEAN_BOT = -64'sd2147483648;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mean;
      logic                too_short;
      logic                saturated;
   } mean_rec_type;

   logic [SCALE_W-1:0]         scale;
   logic signed [SAMPLE_W-1:0] win [0:2];
   logic [CNT_W-1:0]           seen;
   longint                     area;
   mean_rec_type               mean_q [$];

   task automatic clear_window();
      win[0] = '0;
      win[1] = '0;
      win[2] = '0;
      seen   = '0;
      area   = 0;
   endtask

   // Quadrature update for one sample; a final sample queues the expected mean.
   task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] x, input logic fin);
      longint           f1, f2, f3, f4, delta, total, m;
      logic [CNT_W-1:0] n;
      logic signed [95:0] wide;
      mean_rec_type     rec;
      n  = seen;
      f1 = win[0];
      f2 = win[1];
      f3 = win[2];
      f4 = x;
      if (n >= CNT_THREE) begin
         delta = -f1 + 13 * f2 + 13 * f3 - f4;
         if (n == CNT_THREE)
            delta += 9 * f1 + 19 * f2 - 5 * f3 + f4;
         if (fin)
            delta += f1 - 5 * f2 + 19 * f3 + 9 * f4;
         total = area + delta;
         if (total > AREA_TOP)
            total = AREA_TOP;
         if (total < AREA_BOT)
            total = AREA_BOT;
         area = total;
      end
      win[0] = win[1];
      win[1] = win[2];
      win[2] = x;
      if (n < CNT_FULL)
         seen = n + 1'b1;
      if (fin) begin
         rec.mean      = '0;
         rec.too_short = 1'b0;
         rec.saturated = 1'b0;
         if (n < CNT_THREE) begin
            rec.too_short = 1'b1;
         end else begin
            // floor(area * scale / 2^32), scale taken as unsigned
            wide = 96'(area) * $signed({64'd0, scale});
            m    = longint'(wide >>> 32);
            if (m > MEAN_TOP) begin
               m = MEAN_TOP;
               rec.saturated = 1'b1;
            end
            if (m < MEAN_BOT) begin
               m = MEAN_BOT;
               rec.saturated = 1'b1;
            end
            rec.mean = m[SAMPLE_W-1:0];
         end
         mean_q.push_back(rec);
         clear_window();
      end
   endtask

   always @(posedge clock) begin
      mean_rec_type want;
      if (reset) begin
         scale      = '0;
         fail_count = 0;
         clear_window();
         mean_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            scale = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (mean_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: rsp transfer with no sequence pending: mean %h flags %b",
                           $realtime, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = mean_q.pop_front();
               if (rsp_tdata !== want.mean || rsp_tuser[0] !== want.too_short ||
                   rsp_tuser[1] !== want.saturated) begin
                  if (fail_count < 10)
                     $display("%0t: mean %h short %b sat %b, expected mean %h short %b sat %b",
                              $realtime, rsp_tdata, rsp_tuser[0], rsp_tuser[1],
                              want.mean, want.too_short, want.saturated);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb_sample($signed(req_tdata), req_tlast);
      end
      pending = mean_q.size();
   end

endmodule

/* verif/tb.sv */
// Testbench top for cubic_interp_stream_average_unit: clock, reset, sample and
// scale stimulus, rsp back-pressure and the verdict. Uses civ_pkg and civ_mean_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import civ_pkg::*;

   localparam int QUIET_LIMIT     = 4000;
   localparam int LONG_HOLD       = 300;
   localparam int SETTLE          = 10;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid;
   logic                csr_ready;
   logic [SCALE_W-1:0]  csr_wdata;
   logic                req_tvalid;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [SAMPLE_W-1:0] rsp_tdata;
   logic [1:0]          rsp_tuser;
   int                  fail_count;
   int                  pending;
   int                  quiet;
   bit                  idle_on;
   bit                  hold_req;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   cubic_interp_stream_average_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   civ_mean_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Called and returns at a falling edge; valid stays high for a following sample.
   task automatic put_sample(input logic [SAMPLE_W-1:0] s, input logic fin);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3, 4:    return 32'($urandom_range(0, 131071)) - 32'd65536;
         default: return $urandom();
      endcase
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 3)
         return $urandom_range(1, 3);
      if (r == 3)
         return $urandom_range(25, 150);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [SCALE_W-1:0] pick_scale(input int phase);
      case (phase)
         1:       return '0;
         2:       return '1;
         3, 5:    return $urandom();
         default: return 32'((64'd1 << 32) / (64'd24 * $urandom_range(3, 40)));
      endcase
   endfunction

   task automatic put_sequence(input int len);
      for (int i = 0; i < len; i++)
         put_sample(pick_sample(), i == len - 1);
   endtask

   // Let every pending mean arrive, then give the pipeline time to empty.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_scale(input logic [SCALE_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // rsp side: random stall bursts, plus one long hold on request
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int sent;
      csr_valid  = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      idle_on    = 1'b0;
      hold_req   = 1'b0;
      quiet      = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single sample, scale still at its reset value
      put_sample(SAMPLE_MAX, 1'b1);
      write_scale(32'h0AAA_AAAA);
      put_sample(SAMPLE_MIN, 1'b0);
      put_sample(32'hFFFF_FFFF, 1'b1);
      put_sample('0, 1'b0);
      put_sample(32'd1, 1'b0);
      put_sample(SAMPLE_MAX, 1'b1);
      // four samples: first, middle and final interval on one transfer
      put_sample(SAMPLE_MAX, 1'b0);
      put_sample(SAMPLE_MIN, 1'b0);
      put_sample('0, 1'b0);
      put_sample(32'hFFFF_FFFF, 1'b1);
      put_sample(SAMPLE_MIN, 1'b0);
      put_sample(SAMPLE_MAX, 1'b0);
      put_sample(SAMPLE_MAX, 1'b0);
      put_sample(SAMPLE_MIN, 1'b0);
      put_sample(32'h0001_0000, 1'b1);
      // full-scale mean clips both ways
      write_scale('1);
      for (int i = 0; i < 4; i++)
         put_sample(SAMPLE_MAX, i == 3);
      for (int i = 0; i < 4; i++)
         put_sample(SAMPLE_MIN, i == 3);

      for (int phase = 0; phase < PHASES; phase++) begin
         write_scale(pick_scale(phase));
         idle_on = (phase != 3) && (phase < PHASES - 2);
         sent = 0;
         if (phase == 4) begin
            // short sequences against a stalled rsp side fill the pipeline
            hold_req = 1'b1;
            for (int k = 0; k < 40; k++) begin
               int len;
               len = $urandom_range(1, 4);
               put_sequence(len);
               sent += len;
            end
         end
         while (sent < ITEMS_PER_PHASE) begin
            int len;
            len = pick_length();
            put_sequence(len);
            sent += len;
         end
      end

      drain();
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* cubic_interp_stream_average_unit.f */
src/civ_pkg.sv
src/civ_scale.sv
src/cubic_interp_stream_average_unit.sv
verif/civ_mean_checker.sv
verif/tb.sv
